// ===== rtl/chenc_pkg.sv =====
// Shared types and constants for the canonical Huffman encoder.
// Used by canonical_huffman_encoder; no dependencies.
package chenc_pkg;

  localparam int SYMBOL_COUNT  = 256;
  localparam int MAX_CODE_BITS = 15;

  localparam int SYM_W    = 8;
  localparam int LEN_W    = 4;
  localparam int SYM_AW   = $clog2(SYMBOL_COUNT);
  localparam int SCAN_W   = $clog2(SYMBOL_COUNT + 1);
  localparam int HIST_W   = SCAN_W;
  localparam int CODE_W   = MAX_CODE_BITS;
  localparam int RUN_W    = 16;
  localparam int PEND_W   = 7;
  localparam int ACC_W    = PEND_W + (1 << LEN_W) - 1;
  localparam int TOT_W    = $clog2(ACC_W + 1);
  localparam int LEN_LAST = (1 << LEN_W) - 1;
  localparam int Q_DEPTH  = 3;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_BUILD  = 2'd1,
    OP_ENCODE = 2'd2,
    OP_FLUSH  = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    KIND_DATA    = 2'd0,
    KIND_PARTIAL = 2'd1,
    KIND_STATUS  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_CODES  = 2'd1,
    ST_UNCODED   = 2'd2,
    ST_NOT_BUILT = 2'd3
  } status_t;

  typedef struct packed {
    opcode_t            opcode;
    logic [SYM_W-1:0]   symbol;
    logic [LEN_W-1:0]   code_length;
  } in_beat_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  out_byte;
    logic [3:0]  valid_bits;
    status_t     status;
    logic        last;
  } out_beat_t;

endpackage

// ===== rtl/chenc_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module chenc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/canonical_huffman_encoder.sv =====
// Canonical Huffman encoder top level: length and code RAMs, build sequencer,
// bit packer and result queue. Depends on chenc_pkg and chenc_ram.
//
//   channel  dir  handshake            payload
//   in_      in   in_valid / in_stall   in_beat  (in_beat_t)
//   out_     out  out_valid / out_stall out_beat (out_beat_t)
//
// Load and flush are done in S_IDLE; encode adds S_ENC for the length/code RAM read.
// Build holds the input for two sweeps over the length RAM (S_HIST, S_ASSIGN)
// plus one S_FIRST step per code length.
// After reset a clearing pass writes zero to every entry of the length RAM.
// Input stalls while not idle and while two or more results are queued.
// Results leave through a three-entry queue; out_stall only holds that queue.
module canonical_huffman_encoder
  import chenc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_beat_t  in_beat,
  output logic      out_valid,
  input  logic      out_stall,
  output out_beat_t out_beat
);

  typedef enum logic [5:0] {
    S_CLEAR  = 6'b000001,
    S_IDLE   = 6'b000010,
    S_ENC    = 6'b000100,
    S_HIST   = 6'b001000,
    S_FIRST  = 6'b010000,
    S_ASSIGN = 6'b100000
  } state_t;

  state_t               state_r, state_nxt;
  logic [SCAN_W-1:0]    scan_r, scan_nxt;
  logic                 rdv_r, rdv_nxt;
  logic                 coded_r, coded_nxt;
  logic                 ready_r, ready_nxt;
  logic [PEND_W-1:0]    pbits_r, pbits_nxt;
  logic [2:0]           pcnt_r, pcnt_nxt;
  logic [LEN_W-1:0]     lcnt_r, lcnt_nxt;
  logic [LEN_W-1:0]     prev_r, prev_nxt;
  logic [RUN_W-1:0]     run_r, run_nxt;
  logic [SYM_W-1:0]     sym_r, sym_nxt;
  logic [HIST_W-1:0]    hist_r [1 << LEN_W];
  logic [HIST_W-1:0]    hist_nxt [1 << LEN_W];
  logic [RUN_W-1:0]     nc_r [1 << LEN_W];
  logic [RUN_W-1:0]     nc_nxt [1 << LEN_W];

  out_beat_t            q_r [Q_DEPTH];
  out_beat_t            q_nxt [Q_DEPTH];
  logic [1:0]           cnt_r, cnt_nxt;
  logic                 pop;
  logic [1:0]           base;
  logic [1:0]           push_n;
  out_beat_t            push0, push1;

  logic                 lt_we;
  logic [SYM_AW-1:0]    lt_waddr, lt_raddr;
  logic [LEN_W-1:0]     lt_wdata, lt_rdata;
  logic                 ct_we;
  logic [SYM_AW-1:0]    ct_waddr, ct_raddr;
  logic [CODE_W-1:0]    ct_wdata, ct_rdata;

  logic                 in_acc;
  logic                 in_range;
  logic                 sym_r_range;
  logic [LEN_W-1:0]     len_sat;
  logic [ACC_W-1:0]     acc;
  logic [ACC_W-1:0]     code_m;
  logic [TOT_W-1:0]     total;
  logic [TOT_W-1:0]     sh0, sh1;
  logic [2:0]           rem;
  logic [1:0]           nfull;
  logic [RUN_W-1:0]     first;
  logic [PEND_W+7:0]    flush_w;

  chenc_ram #(.WIDTH(LEN_W), .DEPTH(SYMBOL_COUNT)) u_len_ram (
    .clk   (clk),
    .we    (lt_we),
    .waddr (lt_waddr),
    .wdata (lt_wdata),
    .raddr (lt_raddr),
    .rdata (lt_rdata)
  );

  chenc_ram #(.WIDTH(CODE_W), .DEPTH(SYMBOL_COUNT)) u_code_ram (
    .clk   (clk),
    .we    (ct_we),
    .waddr (ct_waddr),
    .wdata (ct_wdata),
    .raddr (ct_raddr),
    .rdata (ct_rdata)
  );

  assign in_stall  = (state_r != S_IDLE) || (cnt_r > 2'd1);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = (cnt_r != 2'd0);
  assign out_beat  = q_r[0];
  assign pop       = out_valid && !out_stall;

  assign in_range    = ({1'b0, in_beat.symbol} < (SYM_W + 1)'(SYMBOL_COUNT));
  assign sym_r_range = ({1'b0, sym_r} < (SYM_W + 1)'(SYMBOL_COUNT));
  assign len_sat     = ({1'b0, in_beat.code_length} > (LEN_W + 1)'(MAX_CODE_BITS)) ?
                       LEN_W'(MAX_CODE_BITS) : in_beat.code_length;

  // bit packer
  assign code_m = ACC_W'(ct_rdata) & ((ACC_W'(1) << lt_rdata) - ACC_W'(1));
  assign acc    = (ACC_W'(pbits_r) << lt_rdata) | code_m;
  assign total  = TOT_W'(pcnt_r) + TOT_W'(lt_rdata);
  assign sh0    = total - TOT_W'(8);
  assign sh1    = total - TOT_W'(16);
  assign rem    = total[2:0];
  assign nfull  = (total >= TOT_W'(16)) ? 2'd2 : ((total >= TOT_W'(8)) ? 2'd1 : 2'd0);

  assign first   = (prev_r != '0) ? (run_r << (lcnt_r - prev_r)) : run_r;
  assign flush_w = (PEND_W + 8)'(pbits_r) << (4'd8 - {1'b0, pcnt_r});

  always_comb begin
    state_nxt = state_r;
    scan_nxt  = scan_r;
    rdv_nxt   = 1'b0;
    coded_nxt = coded_r;
    ready_nxt = ready_r;
    pbits_nxt = pbits_r;
    pcnt_nxt  = pcnt_r;
    lcnt_nxt  = lcnt_r;
    prev_nxt  = prev_r;
    run_nxt   = run_r;
    sym_nxt   = sym_r;
    hist_nxt  = hist_r;
    nc_nxt    = nc_r;
    lt_we     = 1'b0;
    lt_waddr  = scan_r[SYM_AW-1:0];
    lt_wdata  = '0;
    lt_raddr  = scan_r[SYM_AW-1:0];
    ct_we     = 1'b0;
    ct_waddr  = sym_r[SYM_AW-1:0];
    ct_wdata  = nc_r[lt_rdata][CODE_W-1:0];
    ct_raddr  = in_beat.symbol[SYM_AW-1:0];
    push_n    = 2'd0;
    push0     = '{kind: KIND_STATUS, out_byte: 8'd0, valid_bits: 4'd0,
                  status: ST_OK, last: 1'b1};
    push1     = '{kind: KIND_DATA, out_byte: 8'd0, valid_bits: 4'd8,
                  status: ST_OK, last: 1'b1};

    case (state_r)
      S_CLEAR: begin
        lt_we = 1'b1;
        if (scan_r == SCAN_W'(SYMBOL_COUNT - 1)) begin
          scan_nxt  = '0;
          state_nxt = S_IDLE;
        end else begin
          scan_nxt = scan_r + SCAN_W'(1);
        end
      end
      S_IDLE: begin
        lt_raddr = in_beat.symbol[SYM_AW-1:0];
        if (in_acc) begin
          case (in_beat.opcode)
            OP_LOAD: begin
              ready_nxt = 1'b0;
              if (in_range) begin
                lt_we    = 1'b1;
                lt_waddr = in_beat.symbol[SYM_AW-1:0];
                lt_wdata = len_sat;
              end
            end
            OP_BUILD: begin
              for (int i = 0; i < (1 << LEN_W); i++) begin
                hist_nxt[i] = '0;
              end
              coded_nxt = 1'b0;
              scan_nxt  = '0;
              state_nxt = S_HIST;
            end
            OP_ENCODE: begin
              sym_nxt   = in_beat.symbol;
              state_nxt = S_ENC;
            end
            OP_FLUSH: begin
              push_n = 2'd1;
              push0  = '{kind: KIND_PARTIAL, out_byte: flush_w[7:0],
                         valid_bits: {1'b0, pcnt_r}, status: ST_OK, last: 1'b1};
              pbits_nxt = '0;
              pcnt_nxt  = '0;
            end
            default: ;
          endcase
        end
      end
      S_ENC: begin
        state_nxt = S_IDLE;
        if (!ready_r) begin
          push_n       = 2'd1;
          push0.status = ST_NOT_BUILT;
        end else if (!sym_r_range || lt_rdata == '0) begin
          push_n       = 2'd1;
          push0.status = ST_UNCODED;
        end else begin
          push_n = nfull;
          push0  = '{kind: KIND_DATA, out_byte: 8'(acc >> sh0), valid_bits: 4'd8,
                     status: ST_OK, last: (nfull == 2'd1)};
          push1.out_byte = 8'(acc >> sh1);
          pcnt_nxt  = rem;
          pbits_nxt = PEND_W'(acc & ((ACC_W'(1) << rem) - ACC_W'(1)));
        end
      end
      S_HIST: begin
        if (scan_r != SCAN_W'(SYMBOL_COUNT)) begin
          rdv_nxt  = 1'b1;
          scan_nxt = scan_r + SCAN_W'(1);
        end
        if (rdv_r) begin
          hist_nxt[lt_rdata] = hist_r[lt_rdata] + HIST_W'(1);
          if (lt_rdata != '0) begin
            coded_nxt = 1'b1;
          end
        end
        if (scan_r == SCAN_W'(SYMBOL_COUNT) && !rdv_r) begin
          if (coded_r) begin
            lcnt_nxt  = LEN_W'(1);
            prev_nxt  = '0;
            run_nxt   = '0;
            state_nxt = S_FIRST;
          end else begin
            push_n       = 2'd1;
            push0.status = ST_NO_CODES;
            ready_nxt    = 1'b0;
            state_nxt    = S_IDLE;
          end
        end
      end
      S_FIRST: begin
        if (hist_r[lcnt_r] != '0) begin
          nc_nxt[lcnt_r] = first;
          run_nxt        = first + RUN_W'(hist_r[lcnt_r]);
          prev_nxt       = lcnt_r;
        end
        if (lcnt_r == LEN_W'(LEN_LAST)) begin
          scan_nxt  = '0;
          state_nxt = S_ASSIGN;
        end else begin
          lcnt_nxt = lcnt_r + LEN_W'(1);
        end
      end
      S_ASSIGN: begin
        if (scan_r != SCAN_W'(SYMBOL_COUNT)) begin
          rdv_nxt  = 1'b1;
          sym_nxt  = SYM_W'(scan_r);
          scan_nxt = scan_r + SCAN_W'(1);
        end
        if (rdv_r && lt_rdata != '0) begin
          ct_we            = 1'b1;
          nc_nxt[lt_rdata] = nc_r[lt_rdata] + RUN_W'(1);
        end
        if (scan_r == SCAN_W'(SYMBOL_COUNT) && !rdv_r) begin
          push_n    = 2'd1;
          ready_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        scan_nxt  = '0;
        state_nxt = S_CLEAR;
      end
    endcase
  end

  // result queue
  always_comb begin
    q_nxt = q_r;
    base  = cnt_r - {1'b0, pop};
    if (pop) begin
      for (int i = 0; i < Q_DEPTH - 1; i++) begin
        q_nxt[i] = q_r[i + 1];
      end
    end
    for (int i = 0; i < Q_DEPTH; i++) begin
      if (push_n != 2'd0 && 2'(i) == base) begin
        q_nxt[i] = push0;
      end else if (push_n == 2'd2 && 2'(i) == base + 2'd1) begin
        q_nxt[i] = push1;
      end
    end
    cnt_nxt = base + push_n;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      scan_r  <= '0;
      rdv_r   <= 1'b0;
      coded_r <= 1'b0;
      ready_r <= 1'b0;
      pbits_r <= '0;
      pcnt_r  <= '0;
      cnt_r   <= 2'd0;
    end else begin
      state_r <= state_nxt;
      scan_r  <= scan_nxt;
      rdv_r   <= rdv_nxt;
      coded_r <= coded_nxt;
      ready_r <= ready_nxt;
      pbits_r <= pbits_nxt;
      pcnt_r  <= pcnt_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lcnt_r <= lcnt_nxt;
    prev_r <= prev_nxt;
    run_r  <= run_nxt;
    sym_r  <= sym_nxt;
    hist_r <= hist_nxt;
    nc_r   <= nc_nxt;
    q_r    <= q_nxt;
  end

  a_queue_room: assert property (@(posedge clk) disable iff (!rst_n)
    (push_n != 2'd0) |-> ({1'b0, base} + {1'b0, push_n} <= 3'(Q_DEPTH)))
    else $error("result queue overflow");

  a_enc_read: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_beat.opcode == OP_ENCODE) |=> (state_r == S_ENC))
    else $error("encode did not enter read stage");

  a_clear_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> !ready_r)
    else $error("codes ready during clearing pass");

  a_first_coded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIRST) |-> coded_r)
    else $error("code assignment without coded symbols");

endmodule

// ===== dv/tb_canonical_huffman_encoder.sv =====
// Self-checking testbench for canonical_huffman_encoder: directed and random
// load/build/encode/flush beats, with results predicted in-bench and compared.
// Depends on chenc_pkg and the encoder RTL.
module tb_canonical_huffman_encoder;
  import chenc_pkg::*;

  typedef struct {
    in_beat_t beat;
    bit       drain;
  } stim_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_beat_t  in_beat = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_beat_t out_beat;

  stim_t       beat_q[$];
  out_beat_t   predicted_out[$];
  logic [3:0]  gen_len[SYMBOL_COUNT];
  int          coded_syms[$];

  logic [3:0]        p_len[SYMBOL_COUNT];
  logic [CODE_W-1:0] p_code[SYMBOL_COUNT];
  logic              p_ready = 1'b0;
  logic [6:0]        p_pend_bits = '0;
  logic [2:0]        p_pend_cnt = '0;

  int unsigned n_queued = 0, n_accepted = 0, n_results = 0, n_errors = 0;
  int unsigned n_builds = 0, n_encodes = 0, n_flushes = 0, n_loads = 0;
  logic        calm;
  out_beat_t   want;

  assign calm = (n_accepted >= 200) && (n_accepted < 330);

  canonical_huffman_encoder u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_beat   (in_beat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_beat  (out_beat)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    foreach (p_len[i]) begin
      p_len[i] = '0;
      p_code[i] = '0;
      gen_len[i] = '0;
    end
  end

  task automatic huff_predict(input in_beat_t b);
    out_beat_t   r;
    int unsigned hist[16];
    int unsigned coded, code, prev, nb, acc, total, nbytes;
    r = '0;
    r.last = 1'b1;
    case (b.opcode)
      OP_LOAD: begin
        n_loads++;
        p_len[b.symbol] = b.code_length;
        p_ready = 1'b0;
      end
      OP_BUILD: begin
        n_builds++;
        coded = 0;
        code = 0;
        prev = 0;
        foreach (hist[i]) hist[i] = 0;
        for (int s = 0; s < SYMBOL_COUNT; s++) begin
          hist[p_len[s]]++;
          if (p_len[s] != 0) coded++;
        end
        r.kind = KIND_STATUS;
        if (coded == 0) begin
          p_ready = 1'b0;
          r.status = ST_NO_CODES;
        end else begin
          for (int l = 1; l <= LEN_LAST; l++) begin
            if (hist[l] != 0) begin
              if (prev != 0) code = (code << (l - prev)) & 32'hFFFF;
              prev = l;
              for (int s = 0; s < SYMBOL_COUNT; s++) begin
                if (p_len[s] == l) begin
                  p_code[s] = code[CODE_W-1:0];
                  code = (code + 1) & 32'hFFFF;
                end
              end
            end
          end
          p_ready = 1'b1;
          r.status = ST_OK;
        end
        predicted_out.push_back(r);
      end
      OP_ENCODE: begin
        n_encodes++;
        r.kind = KIND_STATUS;
        if (!p_ready) begin
          r.status = ST_NOT_BUILT;
          predicted_out.push_back(r);
        end else if (p_len[b.symbol] == 0) begin
          r.status = ST_UNCODED;
          predicted_out.push_back(r);
        end else begin
          nb = p_len[b.symbol];
          acc = (32'(p_pend_bits) << nb) | (32'(p_code[b.symbol]) & ((32'd1 << nb) - 1));
          total = p_pend_cnt + nb;
          nbytes = total / 8;
          for (int k = 0; k < nbytes; k++) begin
            r.kind = KIND_DATA;
            r.out_byte = 8'(acc >> (total - 8 * (k + 1)));
            r.valid_bits = 4'd8;
            r.status = ST_OK;
            r.last = (k == nbytes - 1);
            predicted_out.push_back(r);
          end
          total = total % 8;
          p_pend_cnt = total[2:0];
          acc = acc & ((32'd1 << total) - 1);
          p_pend_bits = acc[6:0];
        end
      end
      OP_FLUSH: begin
        n_flushes++;
        acc = 32'(p_pend_bits) << (8 - p_pend_cnt);
        r.kind = KIND_PARTIAL;
        r.out_byte = acc[7:0];
        r.valid_bits = {1'b0, p_pend_cnt};
        r.status = ST_OK;
        predicted_out.push_back(r);
        p_pend_bits = '0;
        p_pend_cnt = '0;
      end
      default: ;
    endcase
  endtask

  task automatic note_mismatch(input string what, input out_beat_t exp_r,
                               input out_beat_t got);
    n_errors++;
    if (n_errors <= 10)
      $display("%s: kind/byte/bits/st/last exp %0d/%02h/%0d/%0d/%0d got %0d/%02h/%0d/%0d/%0d",
               what, exp_r.kind, exp_r.out_byte, exp_r.valid_bits, exp_r.status, exp_r.last,
               got.kind, got.out_byte, got.valid_bits, got.status, got.last);
  endtask

  task automatic queue_beat(input opcode_t op, input logic [7:0] sym,
                            input logic [3:0] ln, input bit drain);
    stim_t s;
    s.beat.opcode = op;
    s.beat.symbol = sym;
    s.beat.code_length = ln;
    s.drain = drain;
    beat_q.push_back(s);
    n_queued++;
    if (op == OP_LOAD) gen_len[sym] = ln;
  endtask

  task automatic refresh_coded();
    coded_syms.delete();
    for (int s = 0; s < SYMBOL_COUNT; s++)
      if (gen_len[s] != 0) coded_syms.push_back(s);
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        huff_predict(in_beat);
        n_accepted++;
      end
      if (!in_valid || !in_stall) begin
        if (beat_q.size() != 0 && !(beat_q[0].drain && predicted_out.size() != 0) &&
            (calm || $urandom_range(99) >= 12)) begin
          in_beat <= beat_q[0].beat;
          in_valid <= 1'b1;
          void'(beat_q.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n || calm) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < 12);
    end
    if (rst_n && out_valid && !out_stall) begin
      n_results++;
      if (predicted_out.size() == 0) begin
        note_mismatch("unexpected beat", '0, out_beat);
      end else begin
        want = predicted_out.pop_front();
        if (out_beat.kind !== want.kind || out_beat.out_byte !== want.out_byte ||
            out_beat.valid_bits !== want.valid_bits || out_beat.status !== want.status ||
            out_beat.last !== want.last)
          note_mismatch("mismatch", want, out_beat);
      end
    end
  end

  initial begin
    int unsigned pick, n_sess_loads, n_enc;
    bit          drain;
    logic [7:0]  sym;
    logic [3:0]  ln;

    // directed: error paths, empty flush, tie at max length, overfull code set
    queue_beat(OP_ENCODE, 8'd0, 4'd0, 1'b0);
    queue_beat(OP_FLUSH, 8'd0, 4'd0, 1'b0);
    queue_beat(OP_BUILD, 8'd0, 4'd0, 1'b0);
    queue_beat(OP_ENCODE, 8'd0, 4'd0, 1'b0);
    queue_beat(OP_LOAD, 8'd255, 4'd15, 1'b0);
    queue_beat(OP_LOAD, 8'd0, 4'd1, 1'b0);
    queue_beat(OP_LOAD, 8'd128, 4'd15, 1'b0);
    queue_beat(OP_LOAD, 8'd1, 4'd3, 1'b0);
    queue_beat(OP_ENCODE, 8'd0, 4'd0, 1'b0);
    queue_beat(OP_BUILD, 8'd0, 4'd0, 1'b0);
    queue_beat(OP_ENCODE, 8'd255, 4'd0, 1'b0);
    queue_beat(OP_ENCODE, 8'd128, 4'd0, 1'b0);
    queue_beat(OP_ENCODE, 8'd2, 4'd0, 1'b0);
    queue_beat(OP_ENCODE, 8'd0, 4'd0, 1'b0);
    queue_beat(OP_ENCODE, 8'd1, 4'd0, 1'b0);
    queue_beat(OP_FLUSH, 8'd0, 4'd0, 1'b0);
    queue_beat(OP_LOAD, 8'd10, 4'd1, 1'b0);
    queue_beat(OP_LOAD, 8'd11, 4'd1, 1'b0);
    queue_beat(OP_LOAD, 8'd12, 4'd1, 1'b0);
    queue_beat(OP_BUILD, 8'd0, 4'd0, 1'b0);
    queue_beat(OP_ENCODE, 8'd12, 4'd0, 1'b0);
    queue_beat(OP_ENCODE, 8'd11, 4'd0, 1'b0);
    queue_beat(OP_FLUSH, 8'd0, 4'd0, 1'b0);
    queue_beat(OP_LOAD, 8'd255, 4'd0, 1'b0);
    queue_beat(OP_FLUSH, 8'd0, 4'd0, 1'b0);

    // random sessions: loads, build, encode run, flush; some broken
    drain = 1'b1;
    while (n_queued < 470) begin
      refresh_coded();
      n_sess_loads = $urandom_range(2, 10);
      for (int i = 0; i < n_sess_loads; i++) begin
        if (coded_syms.size() != 0 && $urandom_range(1) == 1)
          sym = 8'(coded_syms[$urandom_range(coded_syms.size() - 1)]);
        else
          sym = 8'($urandom_range(255));
        pick = $urandom_range(99);
        ln = (pick < 15) ? 4'd0 :
             (pick < 30) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(1, 8));
        queue_beat(OP_LOAD, sym, ln, drain && i == 0);
      end
      drain = ($urandom_range(3) == 0);
      refresh_coded();
      if ($urandom_range(99) < 10)
        queue_beat(OP_ENCODE, 8'($urandom_range(255)), 4'($urandom_range(15)), 1'b0);
      if ($urandom_range(99) >= 5)
        queue_beat(OP_BUILD, 8'($urandom_range(255)), 4'($urandom_range(15)), 1'b0);
      n_enc = $urandom_range(5, 40);
      for (int i = 0; i < n_enc; i++) begin
        pick = $urandom_range(99);
        if (pick < 3)
          queue_beat(opcode_t'($urandom_range(3)), 8'($urandom_range(255)),
                     4'($urandom_range(15)), 1'b0);
        else if (pick < 13 || coded_syms.size() == 0)
          queue_beat(OP_ENCODE, 8'($urandom_range(255)), 4'($urandom_range(15)), 1'b0);
        else
          queue_beat(OP_ENCODE, 8'(coded_syms[$urandom_range(coded_syms.size() - 1)]),
                     4'($urandom_range(15)), 1'b0);
      end
      if ($urandom_range(9) != 0)
        queue_beat(OP_FLUSH, 8'($urandom_range(255)), 4'($urandom_range(15)), 1'b0);
      if ($urandom_range(9) == 0)
        queue_beat(OP_FLUSH, 8'($urandom_range(255)), 4'($urandom_range(15)), 1'b0);
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    while (n_accepted != n_queued) @(posedge clk);
    while (predicted_out.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("Sent %0d beats: %0d loads, %0d builds, %0d encodes, %0d flushes",
             n_accepted, n_loads, n_builds, n_encodes, n_flushes);
    $display("Checked %0d result beats, %0d errors", n_results, n_errors);
    if (n_errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timeout with %0d beats unsent and %0d results outstanding",
             beat_q.size(), predicted_out.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule
